FILE: hdl/dual_lane_8b10b_interleaver_assert.svh
// Assertion macros for the dual-lane 8b/10b interleaver.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef DUAL_LANE_8B10B_INTERLEAVER_ASSERT_SVH
`define DUAL_LANE_8B10B_INTERLEAVER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define DL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error("dual lane 8b10b interleaver check failed");

// Checked on every clock edge, reset included.
`define DL_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
    else $error("dual lane 8b10b interleaver reset check failed");

`endif

FILE: hdl/dl8b10b_pkg.sv
// Shared constants and code tables for the dual-lane 8b/10b interleaver.
// No dependencies.
package dl8b10b_pkg;

    localparam int unsigned CODE_W = 10;
    localparam int unsigned WORD_W = 20;

    // Sync word sent ahead of every transfer.
    localparam logic [WORD_W-1:0] SYNC_WORD = 20'hCC00F;

    // Alternate 3b/4b code for D.x.A7, written with f as the MSB.
    localparam logic [3:0] ALT7_CODE = 4'h7;

    // Special 5b values.
    localparam logic [4:0] X_D07 = 5'd7;
    localparam logic [2:0] Y_D3  = 3'd3;
    localparam logic [2:0] Y_D7  = 3'd7;

    typedef logic [5:0] t_six_tbl  [32];
    typedef logic [3:0] t_four_tbl [8];

    // RD- 5b/6b codes, a as the MSB.
    localparam t_six_tbl SIX_TABLE = '{
        6'h27, 6'h1D, 6'h2D, 6'h31, 6'h35, 6'h29, 6'h19, 6'h38,
        6'h39, 6'h25, 6'h15, 6'h34, 6'h0D, 6'h2C, 6'h1C, 6'h17,
        6'h1B, 6'h23, 6'h13, 6'h32, 6'h0B, 6'h2A, 6'h1A, 6'h3A,
        6'h33, 6'h26, 6'h16, 6'h36, 6'h0E, 6'h2E, 6'h1E, 6'h2B
    };

    // RD- 3b/4b codes, f as the MSB.
    localparam t_four_tbl FOUR_TABLE = '{
        4'hB, 4'h9, 4'h5, 4'hC, 4'hD, 4'hA, 4'h6, 4'hE
    };

endpackage

FILE: hdl/dual_lane_8b10b_interleaver.sv
// Dual-lane 8b/10b encoder with bit interleaving: lane A on even word bits,
// lane B on odd word bits. Depends on dl8b10b_pkg and dl8b10b_lane_enc.
//
// Usage: each input beat carries a byte pair; within a transfer one 20-bit
// word leaves per cycle while m_axis_tready holds, so a steady stream runs
// at one beat per cycle. The first beat of a transfer emits two words (sync
// word 0xCC00F, then the encoded word) and a beat with tlast one more (the
// transfer's first encoded word again, flagged with tlast). The single
// output port limits the input: beats are held in one input register until
// all of their output words are loaded into the output register, and each
// passes the input register, then the output register. Each lane starts
// every transfer at negative running disparity.
`include "dual_lane_8b10b_interleaver_assert.svh"

module dual_lane_8b10b_interleaver
    import dl8b10b_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] byte_a, [15:8] byte_b
    input  logic        s_axis_tlast,   // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [19:0] word, [23:20] zero
    output logic        m_axis_tlast    // last_word
);

    // Emission phases of the held beat
    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_SYNC   = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_REPEAT = 2'd3;

    logic              r_in_valid;
    logic [7:0]        r_byte_a;
    logic [7:0]        r_byte_b;
    logic              r_in_last;
    logic [1:0]        r_phase;
    logic [1:0]        n_phase;
    logic              r_in_transfer;
    logic              r_capture;
    logic              r_disp_a;
    logic              r_disp_b;
    logic [WORD_W-1:0] r_first_word;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic              r_out_last;

    logic [1:0]        w_cur_phase;
    logic              w_out_load;
    logic              w_emit;
    logic              w_final;
    logic              w_in_free;
    logic [CODE_W-1:0] w_code_a;
    logic [CODE_W-1:0] w_code_b;
    logic              w_rd_a;
    logic              w_rd_b;
    logic [WORD_W-1:0] w_word;
    logic [WORD_W-1:0] n_out_word;
    logic              n_out_last;

    dl8b10b_lane_enc u_lane_a (
        .i_byte (r_byte_a),
        .i_rd   (r_disp_a),
        .o_code (w_code_a),
        .o_rd   (w_rd_a)
    );

    dl8b10b_lane_enc u_lane_b (
        .i_byte (r_byte_b),
        .i_rd   (r_disp_b),
        .o_code (w_code_b),
        .o_rd   (w_rd_b)
    );

    // Interleave: lane A on even bits, lane B on odd bits
    always_comb begin
        for (int j = 0; j < CODE_W; j++) begin
            w_word[2*j]   = w_code_a[j];
            w_word[2*j+1] = w_code_b[j];
        end
    end

    // Resolve the phase of a fresh beat from the transfer flag
    always_comb begin
        if (r_phase == PH_START) begin
            w_cur_phase = r_in_transfer ? PH_DATA : PH_SYNC;
        end else begin
            w_cur_phase = r_phase;
        end
    end

    assign w_out_load = !r_out_valid || m_axis_tready;
    assign w_emit     = r_in_valid && w_out_load;
    assign w_final    = (w_cur_phase == PH_REPEAT) ||
                        (w_cur_phase == PH_DATA && !r_in_last);
    assign w_in_free  = !r_in_valid || (w_emit && w_final);

    // Select the word for the current phase and the phase after it
    always_comb begin
        n_out_word = w_word;
        n_out_last = 1'b0;
        n_phase    = r_phase;
        case (w_cur_phase)
            PH_SYNC: begin
                n_out_word = SYNC_WORD;
                n_phase    = PH_DATA;
            end
            PH_DATA: begin
                n_out_word = w_word;
                n_phase    = PH_REPEAT;
            end
            PH_REPEAT: begin
                n_out_word = r_first_word;
                n_out_last = 1'b1;
                n_phase    = PH_START;
            end
            default: begin
                n_out_word = w_word;
                n_phase    = r_phase;
            end
        endcase
    end

    // Input register: take a beat once the held one has left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_START;
        end else if (w_in_free) begin
            r_in_valid <= s_axis_tvalid;
            r_phase    <= PH_START;
        end else if (w_emit) begin
            r_phase    <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_free && s_axis_tvalid) begin
            r_byte_a  <= s_axis_tdata[7:0];
            r_byte_b  <= s_axis_tdata[15:8];
            r_in_last <= s_axis_tlast;
        end
    end

    // Transfer state: disparities, first word, in-transfer flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_transfer <= 1'b0;
            r_capture     <= 1'b0;
            r_disp_a      <= 1'b0;
            r_disp_b      <= 1'b0;
            r_first_word  <= '0;
        end else if (w_emit) begin
            case (w_cur_phase)
                PH_SYNC: begin
                    r_in_transfer <= 1'b1;
                    r_capture     <= 1'b1;
                    r_disp_a      <= 1'b0;
                    r_disp_b      <= 1'b0;
                end
                PH_DATA: begin
                    r_disp_a  <= w_rd_a;
                    r_disp_b  <= w_rd_b;
                    r_capture <= 1'b0;
                    if (r_capture) begin
                        r_first_word <= w_word;
                    end
                end
                PH_REPEAT: begin
                    r_in_transfer <= 1'b0;
                end
                default: begin
                    r_capture <= r_capture;
                end
            endcase
        end
    end

    // Output register: load whenever empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_word <= n_out_word;
            r_out_last <= n_out_last;
        end
    end

    assign s_axis_tready = w_in_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_word};
    assign m_axis_tlast  = r_out_last;

    // Sync starts a transfer at negative disparity on both lanes
    `DL_ASSERT(a_sync_resets_rd,
        w_emit && w_cur_phase == PH_SYNC |=> r_in_transfer && !r_disp_a && !r_disp_b)
    // Repeated word closes the transfer
    `DL_ASSERT(a_repeat_ends_xfer, w_emit && w_cur_phase == PH_REPEAT |=> !r_in_transfer)
    // A flagged word is the stored first word of its transfer
    `DL_ASSERT(a_last_is_first, r_out_valid && r_out_last |-> r_out_word == r_first_word)
    // Nothing is offered right after reset
    `DL_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !r_out_valid && !r_in_valid)

endmodule

FILE: hdl/dl8b10b_lane_enc.sv
// One lane of 8b/10b encoding: 5b/6b and 3b/4b with running disparity.
// Depends on dl8b10b_pkg for the code tables.
module dl8b10b_lane_enc
    import dl8b10b_pkg::*;
(
    input  logic [7:0]        i_byte,
    input  logic              i_rd,     // 0 = RD-, 1 = RD+
    output logic [CODE_W-1:0] o_code,   // bit 0 = a, bits 9:6 = fghj
    output logic              o_rd
);

    logic [4:0] w_x;
    logic [2:0] w_y;
    logic [5:0] w_c6;
    logic [3:0] w_c4;
    logic       w_unbal6;
    logic       w_unbal4;
    logic       w_rd_mid;
    logic       w_alt;

    assign w_x = i_byte[4:0];
    assign w_y = i_byte[7:5];

    // 5b/6b stage: complement under RD+ for unbalanced codes and D.7
    always_comb begin
        w_unbal6 = ($countones(SIX_TABLE[w_x]) != 3);
        if (i_rd && (w_unbal6 || w_x == X_D07)) begin
            w_c6 = ~SIX_TABLE[w_x];
        end else begin
            w_c6 = SIX_TABLE[w_x];
        end
        w_rd_mid = i_rd ^ w_unbal6;
    end

    // 3b/4b stage: pick A7 where P7 would make a run of five
    always_comb begin
        w_alt = (w_y == Y_D7) &&
                (( w_rd_mid && (w_x inside {5'd11, 5'd13, 5'd14})) ||
                 (!w_rd_mid && (w_x inside {5'd17, 5'd18, 5'd20})));
        if (w_alt) begin
            w_c4 = ALT7_CODE;
        end else begin
            w_c4 = FOUR_TABLE[w_y];
        end
        w_unbal4 = ($countones(w_c4) != 2);
        if (w_rd_mid && (w_unbal4 || w_y == Y_D3)) begin
            w_c4 = ~w_c4;
        end
        o_rd = w_rd_mid ^ w_unbal4;
    end

    // Put a at bit 0 and f at bit 6
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            o_code[i] = w_c6[5-i];
        end
        for (int i = 0; i < 4; i++) begin
            o_code[6+i] = w_c4[3-i];
        end
    end

endmodule
